/* hw/rtl/pmm_pkg.sv */
// ----------------------------------------------------------------------------
// pmm_pkg
// Shared types, codes and default sizes for the paged memory manager.
// ----------------------------------------------------------------------------
package pmm_pkg;

  // default geometry (page size is taken as a power of two)
  localparam int VIRT_PAGES_DEF   = 1024;
  localparam int PHYS_FRAMES_DEF  = 256;
  localparam int REGION_SLOTS_DEF = 64;
  localparam int PAGE_BYTES_DEF   = 4 * 1024;

  // request actions
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_ALLOC = 2'd2;
  localparam logic [1:0] ACT_FREE  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_RANGE  = 3'd1;
  localparam logic [2:0] ST_NOREC  = 3'd2;
  localparam logic [2:0] ST_SPACE  = 3'd3;
  localparam logic [2:0] ST_NORES  = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  pid;
    logic [21:0] vaddr;
    logic [22:0] req_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] phys_addr;
    logic [21:0] alloc_base;
    logic        swapped;
    logic [9:0]  evicted_page;
    logic [9:0]  fetched_page;
  } rsp_t;

  // datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_FAIL_RANGE,
    OP_FAIL_NOREC,
    OP_FAIL_SPACE,
    OP_FAIL_NORES,
    OP_SLOT_NEXT,
    OP_SLOT_TAKE,
    OP_PS_CK,
    OP_FILL_INIT,
    OP_F_INC,
    OP_FILL_WR,
    OP_ALLOC_FIN,
    OP_FREE_CK,
    OP_AC_RD,
    OP_AC_HIT,
    OP_SW_INIT,
    OP_SW_STEP,
    OP_SW_EVICT,
    OP_SW_FETCH
  } op_t;

  // datapath status back to the controller
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_free;
    logic size_bad;
    logic range_bad;
    logic slot_match;
    logic slot_last;
    logic ps_hit;
    logic ps_last;
    logic f_busy;
    logic fill_last;
    logic free_last;
    logic ac_res;
    logic sw_found;
    logic sw_last;
  } dp_stat_t;

endpackage

/* hw/rtl/paged_memory_manager_clock.sv */
// ----------------------------------------------------------------------------
// paged_memory_manager_clock
// Bitmap page allocator with region records and clock page replacement.
// ----------------------------------------------------------------------------
// Usage: a request word is taken when start is high and busy is low; its
// result word appears on rsp for exactly one cycle with done high, and the
// receiver cannot stall it. After reset the block clears its page table and
// frame map, one entry a cycle, with busy high. Every request yields one
// result word. Work is element-serial through stores with registered reads:
// region lookup scans the region slots, allocate scans the bitmap of used
// pages for a free run and then places each page, skipping used frames,
// free releases each page of the region, and a miss runs the clock sweep.
// A new request may be given in the same cycle that done is high.
// ----------------------------------------------------------------------------
module paged_memory_manager_clock #(
  parameter int VIRT_PAGES   = pmm_pkg::VIRT_PAGES_DEF,
  parameter int PHYS_FRAMES  = pmm_pkg::PHYS_FRAMES_DEF,
  parameter int REGION_SLOTS = pmm_pkg::REGION_SLOTS_DEF,
  parameter int PAGE_BYTES   = pmm_pkg::PAGE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pmm_pkg::req_t req,
  output logic          done,
  output pmm_pkg::rsp_t rsp
);

  // command and status between sequencer and datapath
  pmm_pkg::op_t      op;
  pmm_pkg::dp_stat_t stat;

  pmm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy),
    .done  (done)
  );

  // stores: page entries, frame bitmap, region records (valid bits in flops)
  pmm_dpath #(
    .VIRT_PAGES   (VIRT_PAGES),
    .PHYS_FRAMES  (PHYS_FRAMES),
    .REGION_SLOTS (REGION_SLOTS),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .req_in (req),
    .stat   (stat),
    .rsp    (rsp)
  );

endmodule

/* hw/rtl/pmm_dpath.sv */
// ----------------------------------------------------------------------------
// pmm_dpath
// Page table, frame map and region record stores with their counters.
// ----------------------------------------------------------------------------
module pmm_dpath #(
  parameter int VIRT_PAGES   = pmm_pkg::VIRT_PAGES_DEF,
  parameter int PHYS_FRAMES  = pmm_pkg::PHYS_FRAMES_DEF,
  parameter int REGION_SLOTS = pmm_pkg::REGION_SLOTS_DEF,
  parameter int PAGE_BYTES   = pmm_pkg::PAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pmm_pkg::op_t      op,
  input  pmm_pkg::req_t     req_in,
  output pmm_pkg::dp_stat_t stat,
  output pmm_pkg::rsp_t     rsp
);

  localparam int VPW   = $clog2(VIRT_PAGES);
  localparam int FW    = $clog2(PHYS_FRAMES);
  localparam int OFFW  = $clog2(PAGE_BYTES);
  localparam int SLW   = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int CLRN  = (VIRT_PAGES > PHYS_FRAMES) ? VIRT_PAGES : PHYS_FRAMES;
  localparam int MAXN  = (CLRN > REGION_SLOTS) ? CLRN : REGION_SLOTS;
  localparam int CW    = $clog2(2 * MAXN);
  localparam int PW    = FW + 3;
  localparam int RW    = 10 + VPW + 23;
  localparam int U_BIT = FW + 2;   // page in use by a region
  localparam int R_BIT = FW + 1;   // resident
  localparam int S_BIT = FW;       // use (reference) bit
  localparam logic [63:0] VIRT_BYTES = 64'(VIRT_PAGES) << OFFW;

  // stores
  logic [PW-1:0] page_mem  [VIRT_PAGES];
  logic          frame_mem [PHYS_FRAMES];
  logic [RW-1:0] rec_mem   [REGION_SLOTS];
  logic [REGION_SLOTS-1:0] valid;

  logic [PW-1:0] page_q;
  logic          frame_q;
  logic [RW-1:0] rec_q;

  // working registers
  pmm_pkg::req_t req;
  pmm_pkg::rsp_t res;
  logic [CW-1:0]  cnt;
  logic [VPW-1:0] ptr;
  logic [VPW:0]   run;
  logic [VPW-1:0] start_pg;
  logic [VPW:0]   np;
  logic [FW:0]    f;
  logic [SLW-1:0] slot;
  logic [FW-1:0]  evf;

  // decode
  logic [63:0]     vaddr64, size64, np_req64, np_rec64, base64, pa_hit64, pa_sw64, ab64;
  logic [VPW-1:0]  v;
  logic [OFFW-1:0] off;
  logic [9:0]      rq_pid;
  logic [VPW-1:0]  rq_page;
  logic [22:0]     rq_size;
  logic            slot_v, pid_eq, fok;
  logic [VPW:0]    run_inc;

  // memory ports
  logic           page_we, frame_we, frame_wd;
  logic [VPW-1:0] page_wa, page_ra;
  logic [PW-1:0]  page_wd;
  logic [FW-1:0]  frame_wa;

  always_comb begin
    vaddr64  = 64'(req.vaddr);
    size64   = 64'(req.req_size);
    np_req64 = (size64 + 64'(PAGE_BYTES - 1)) >> OFFW;
    v        = VPW'(vaddr64 >> OFFW);
    off      = req.vaddr[OFFW-1:0];
    rq_pid   = rec_q[RW-1 -: 10];
    rq_page  = rec_q[23 +: VPW];
    rq_size  = rec_q[22:0];
    np_rec64 = (64'(rq_size) + 64'(PAGE_BYTES - 1)) >> OFFW;
    base64   = 64'(rq_page) << OFFW;
    pa_hit64 = (64'(page_q[FW-1:0]) << OFFW) | 64'(off);
    pa_sw64  = (64'(evf) << OFFW) | 64'(off);
    ab64     = 64'(start_pg) << OFFW;
    slot_v   = valid[cnt[SLW-1:0]];
    pid_eq   = (rq_pid == req.pid);
    fok      = (f < (FW+1)'(PHYS_FRAMES));
    run_inc  = run + 1'b1;
  end

  always_comb begin
    stat.clr_last  = (cnt == CW'(CLRN - 1));
    stat.is_alloc  = (req.action == pmm_pkg::ACT_ALLOC);
    stat.is_free   = (req.action == pmm_pkg::ACT_FREE);
    stat.size_bad  = (size64 == 64'd0) || (size64 > VIRT_BYTES);
    stat.range_bad = (vaddr64 >= VIRT_BYTES);
    if (req.action == pmm_pkg::ACT_ALLOC) begin
      stat.slot_match = !slot_v;
    end else if (req.action == pmm_pkg::ACT_FREE) begin
      stat.slot_match = slot_v && pid_eq && (vaddr64 == base64);
    end else begin
      stat.slot_match = slot_v && pid_eq && (vaddr64 >= base64) &&
                        (vaddr64 < base64 + 64'(rq_size));
    end
    stat.slot_last = (cnt == CW'(REGION_SLOTS - 1));
    stat.ps_hit    = !page_q[U_BIT] && (run_inc == np);
    stat.ps_last   = (ptr == VPW'(VIRT_PAGES - 1));
    stat.f_busy    = fok && frame_q;
    stat.fill_last = ((cnt + 1'b1) == CW'(np));
    stat.free_last = ((cnt + 1'b1) == CW'(np)) || (ptr == VPW'(VIRT_PAGES - 1));
    stat.ac_res    = page_q[R_BIT];
    stat.sw_found  = page_q[R_BIT] && !page_q[S_BIT];
    stat.sw_last   = (cnt == CW'(2 * VIRT_PAGES - 1));
  end

  // write port steering
  always_comb begin
    page_we  = 1'b0;
    page_wa  = ptr;
    page_wd  = '0;
    page_ra  = (op == pmm_pkg::OP_AC_RD) ? v : ptr;
    frame_we = 1'b0;
    frame_wa = f[FW-1:0];
    frame_wd = 1'b0;
    case (op)
      pmm_pkg::OP_CLEAR: begin
        page_we  = 1'b1;
        page_wa  = cnt[VPW-1:0];
        frame_we = (cnt < CW'(PHYS_FRAMES));
        frame_wa = cnt[FW-1:0];
      end
      pmm_pkg::OP_FILL_WR: begin
        page_we         = 1'b1;
        page_wd[U_BIT]  = 1'b1;
        page_wd[R_BIT]  = fok;
        page_wd[FW-1:0] = fok ? f[FW-1:0] : '0;
        frame_we        = fok;
        frame_wd        = 1'b1;
      end
      pmm_pkg::OP_FREE_CK: begin
        page_we  = 1'b1;
        frame_we = page_q[R_BIT];
        frame_wa = page_q[FW-1:0];
      end
      pmm_pkg::OP_AC_HIT: begin
        page_we        = 1'b1;
        page_wa        = v;
        page_wd        = page_q;
        page_wd[S_BIT] = 1'b1;
      end
      pmm_pkg::OP_SW_STEP: begin
        page_we        = page_q[R_BIT] && page_q[S_BIT];
        page_wd        = page_q;
        page_wd[S_BIT] = 1'b0;
      end
      pmm_pkg::OP_SW_EVICT: begin
        page_we        = 1'b1;
        page_wd[U_BIT] = page_q[U_BIT];
      end
      pmm_pkg::OP_SW_FETCH: begin
        page_we         = 1'b1;
        page_wa         = v;
        page_wd[U_BIT]  = 1'b1;
        page_wd[R_BIT]  = 1'b1;
        page_wd[S_BIT]  = 1'b1;
        page_wd[FW-1:0] = evf;
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (page_we) begin
      page_mem[page_wa] <= page_wd;
    end
    page_q <= page_mem[page_ra];
  end

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_wa] <= frame_wd;
    end
    frame_q <= frame_mem[f[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (op == pmm_pkg::OP_ALLOC_FIN) begin
      rec_mem[slot] <= {req.pid, start_pg, req.req_size};
    end
    rec_q <= rec_mem[cnt[SLW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      valid <= '0;
    end else begin
      case (op)
        pmm_pkg::OP_CLEAR:     cnt <= cnt + 1'b1;
        pmm_pkg::OP_LATCH:     cnt <= '0;
        pmm_pkg::OP_SLOT_NEXT: cnt <= cnt + 1'b1;
        pmm_pkg::OP_SLOT_TAKE: begin
          cnt <= '0;
          if (req.action == pmm_pkg::ACT_FREE) begin
            valid[cnt[SLW-1:0]] <= 1'b0;
          end
        end
        pmm_pkg::OP_FILL_INIT: cnt <= '0;
        pmm_pkg::OP_FILL_WR:   cnt <= cnt + 1'b1;
        pmm_pkg::OP_ALLOC_FIN: valid[slot] <= 1'b1;
        pmm_pkg::OP_FREE_CK:   cnt <= cnt + 1'b1;
        pmm_pkg::OP_SW_INIT:   cnt <= '0;
        pmm_pkg::OP_SW_STEP:   cnt <= cnt + 1'b1;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      pmm_pkg::OP_LATCH: begin
        req <= req_in;
        res <= '0;
      end
      pmm_pkg::OP_FAIL_RANGE: res.status <= pmm_pkg::ST_RANGE;
      pmm_pkg::OP_FAIL_NOREC: res.status <= pmm_pkg::ST_NOREC;
      pmm_pkg::OP_FAIL_SPACE: res.status <= pmm_pkg::ST_SPACE;
      pmm_pkg::OP_FAIL_NORES: res.status <= pmm_pkg::ST_NORES;
      pmm_pkg::OP_SLOT_TAKE: begin
        slot <= cnt[SLW-1:0];
        run  <= '0;
        if (req.action == pmm_pkg::ACT_ALLOC) begin
          np  <= (VPW+1)'(np_req64);
          ptr <= '0;
        end else begin
          np  <= (VPW+1)'(np_rec64);
          ptr <= rq_page;
        end
      end
      pmm_pkg::OP_PS_CK: begin
        if (page_q[U_BIT]) begin
          run <= '0;
        end else begin
          run <= run_inc;
          if (run == '0) begin
            start_pg <= ptr;
          end
        end
        ptr <= ptr + 1'b1;
      end
      pmm_pkg::OP_FILL_INIT: begin
        ptr <= start_pg;
        f   <= '0;
      end
      pmm_pkg::OP_F_INC:   f   <= f + 1'b1;
      pmm_pkg::OP_FILL_WR: ptr <= ptr + 1'b1;
      pmm_pkg::OP_ALLOC_FIN: res.alloc_base <= 22'(ab64);
      pmm_pkg::OP_FREE_CK: ptr <= ptr + 1'b1;
      pmm_pkg::OP_AC_HIT:  res.phys_addr <= 20'(pa_hit64);
      pmm_pkg::OP_SW_INIT: ptr <= v >> 2;
      pmm_pkg::OP_SW_STEP: ptr <= (ptr == '0) ? VPW'(VIRT_PAGES - 1) : ptr - 1'b1;
      pmm_pkg::OP_SW_EVICT: begin
        evf              <= page_q[FW-1:0];
        res.swapped      <= 1'b1;
        res.evicted_page <= 10'(ptr);
        res.fetched_page <= 10'(v);
      end
      pmm_pkg::OP_SW_FETCH: res.phys_addr <= 20'(pa_sw64);
      default: begin
      end
    endcase
  end

  assign rsp = res;

endmodule

/* hw/rtl/pmm_ctrl.sv */
// ----------------------------------------------------------------------------
// pmm_ctrl
// Sequencer for the memory manager: issues one datapath command a cycle.
// ----------------------------------------------------------------------------
module pmm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pmm_pkg::dp_stat_t stat,
  output pmm_pkg::op_t      op,
  output logic              busy,
  output logic              done
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SLOT_RD, S_SLOT_CK, S_PS_RD, S_PS_CK,
    S_FILL_INIT, S_FRM_RD, S_FRM_CK, S_ALLOC_FIN, S_FREE_RD, S_FREE_CK,
    S_AC_RD, S_AC_CK, S_SW_RD, S_SW_CK, S_SW_FETCH, S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    op         = pmm_pkg::OP_NONE;
    case (state)
      S_CLEAR: begin
        op = pmm_pkg::OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE, S_DONE: begin
        if (start) begin
          op         = pmm_pkg::OP_LATCH;
          state_next = S_DECODE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DECODE: begin
        state_next = S_SLOT_RD;
        if (stat.is_alloc && stat.size_bad) begin
          op         = pmm_pkg::OP_FAIL_SPACE;
          state_next = S_DONE;
        end else if (!stat.is_alloc && stat.range_bad) begin
          op         = pmm_pkg::OP_FAIL_RANGE;
          state_next = S_DONE;
        end
      end
      S_SLOT_RD: state_next = S_SLOT_CK;
      S_SLOT_CK: begin
        if (stat.slot_match) begin
          op = pmm_pkg::OP_SLOT_TAKE;
          if (stat.is_alloc)     state_next = S_PS_RD;
          else if (stat.is_free) state_next = S_FREE_RD;
          else                   state_next = S_AC_RD;
        end else if (stat.slot_last) begin
          op         = stat.is_alloc ? pmm_pkg::OP_FAIL_SPACE : pmm_pkg::OP_FAIL_NOREC;
          state_next = S_DONE;
        end else begin
          op         = pmm_pkg::OP_SLOT_NEXT;
          state_next = S_SLOT_RD;
        end
      end
      S_PS_RD: state_next = S_PS_CK;
      S_PS_CK: begin
        op = pmm_pkg::OP_PS_CK;
        if (stat.ps_hit) begin
          state_next = S_FILL_INIT;
        end else if (stat.ps_last) begin
          op         = pmm_pkg::OP_FAIL_SPACE;
          state_next = S_DONE;
        end else begin
          state_next = S_PS_RD;
        end
      end
      S_FILL_INIT: begin
        op         = pmm_pkg::OP_FILL_INIT;
        state_next = S_FRM_RD;
      end
      S_FRM_RD: state_next = S_FRM_CK;
      S_FRM_CK: begin
        if (stat.f_busy) begin
          op         = pmm_pkg::OP_F_INC;
          state_next = S_FRM_RD;
        end else begin
          op         = pmm_pkg::OP_FILL_WR;
          state_next = stat.fill_last ? S_ALLOC_FIN : S_FRM_RD;
        end
      end
      S_ALLOC_FIN: begin
        op         = pmm_pkg::OP_ALLOC_FIN;
        state_next = S_DONE;
      end
      S_FREE_RD: state_next = S_FREE_CK;
      S_FREE_CK: begin
        op         = pmm_pkg::OP_FREE_CK;
        state_next = stat.free_last ? S_DONE : S_FREE_RD;
      end
      S_AC_RD: begin
        op         = pmm_pkg::OP_AC_RD;
        state_next = S_AC_CK;
      end
      S_AC_CK: begin
        if (stat.ac_res) begin
          op         = pmm_pkg::OP_AC_HIT;
          state_next = S_DONE;
        end else begin
          op         = pmm_pkg::OP_SW_INIT;
          state_next = S_SW_RD;
        end
      end
      S_SW_RD: state_next = S_SW_CK;
      S_SW_CK: begin
        if (stat.sw_found) begin
          op         = pmm_pkg::OP_SW_EVICT;
          state_next = S_SW_FETCH;
        end else if (stat.sw_last) begin
          op         = pmm_pkg::OP_FAIL_NORES;
          state_next = S_DONE;
        end else begin
          op         = pmm_pkg::OP_SW_STEP;
          state_next = S_SW_RD;
        end
      end
      S_SW_FETCH: begin
        op         = pmm_pkg::OP_SW_FETCH;
        state_next = S_DONE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= !(state_next == S_IDLE || state_next == S_DONE);
      done  <= (state_next == S_DONE);
    end
  end

endmodule

/* dv/tb_paged_memory_manager_clock.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paged_memory_manager_clock
// Self-checking bench for the paged memory manager: a directed table covers
// reset state, size and address extremes, error codes and the no-resident
// case; random traffic then allocates, touches and frees regions with
// noise, pushing the sweep through frame exhaustion and wrap. Each result
// word is checked against the table's expected word or an in-bench model.
// ----------------------------------------------------------------------------
module tb_paged_memory_manager_clock;

  localparam int VP     = pmm_pkg::VIRT_PAGES_DEF;
  localparam int PF     = pmm_pkg::PHYS_FRAMES_DEF;
  localparam int RS     = pmm_pkg::REGION_SLOTS_DEF;
  localparam int PB     = pmm_pkg::PAGE_BYTES_DEF;
  localparam int VBYTES = VP * PB;
  localparam int REQ_W  = $bits(pmm_pkg::req_t);
  // worst item: slot scan + bitmap scan + placement + full sweep, plus the
  // clearing pass after reset and sender gaps, taken several times over
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int RANDOM_WORDS   = 270;
  localparam int DRAIN_CYCLES   = 64;

  logic clk, rst, start, busy, done;
  pmm_pkg::req_t req;
  pmm_pkg::rsp_t rsp;

  paged_memory_manager_clock DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // ---- model of the allocator state ----
  bit        vpage_used [VP];
  bit        frame_used [PF];
  int        pte_frame  [VP];
  bit        pte_res    [VP];
  bit        pte_use    [VP];
  bit        rgn_valid  [RS];
  int        rgn_pid    [RS];
  int        rgn_base   [RS];
  int        rgn_size   [RS];

  pmm_pkg::rsp_t pending_rsp[$];
  int   mismatches;
  int   idle_cycles;

  // Works out one result word and updates the model state.
  function automatic pmm_pkg::rsp_t predict_rsp(pmm_pkg::req_t r);
    pmm_pkg::rsp_t o;
    int   np, run, first, slot, f, p, v, off, s, n, va, sz;
    bit   found;
    o     = '0;
    va    = int'(r.vaddr);
    sz    = int'(r.req_size);
    slot  = -1;
    found = 1'b0;
    case (r.action)
      pmm_pkg::ACT_ALLOC: begin
        o.status = pmm_pkg::ST_SPACE;
        if (sz != 0 && sz <= VBYTES) begin
          np = (sz + PB - 1) / PB;
          for (int i = 0; i < RS; i++)
            if (!rgn_valid[i]) begin slot = i; break; end
          run = 0; first = 0;
          for (p = 0; p < VP; p++) begin
            if (vpage_used[p]) run = 0;
            else begin
              if (run == 0) first = p;
              run++;
              if (run == np) break;
            end
          end
          if (slot >= 0 && run >= np) begin
            f = 0;
            for (p = first; p < first + np; p++) begin
              vpage_used[p] = 1'b1;
              while (f < PF && frame_used[f]) f++;
              pte_use[p] = 1'b0;
              if (f < PF) begin
                frame_used[f] = 1'b1;
                pte_frame[p]  = f;
                pte_res[p]    = 1'b1;
              end else begin
                pte_frame[p] = 0;
                pte_res[p]   = 1'b0;
              end
            end
            rgn_valid[slot] = 1'b1;
            rgn_pid[slot]   = int'(r.pid);
            rgn_base[slot]  = first * PB;
            rgn_size[slot]  = sz;
            o.status        = pmm_pkg::ST_OK;
            o.alloc_base    = 22'(first * PB);
          end
        end
      end
      pmm_pkg::ACT_FREE: begin
        for (int i = 0; i < RS; i++)
          if (rgn_valid[i] && rgn_pid[i] == int'(r.pid) && rgn_base[i] == va) begin
            slot = i; break;
          end
        if (slot < 0) o.status = pmm_pkg::ST_NOREC;
        else begin
          rgn_valid[slot] = 1'b0;
          first = rgn_base[slot] / PB;
          np    = (rgn_size[slot] + PB - 1) / PB;
          for (p = first; p < first + np && p < VP; p++) begin
            vpage_used[p] = 1'b0;
            if (pte_res[p]) frame_used[pte_frame[p]] = 1'b0;
            pte_frame[p] = 0;
            pte_res[p]   = 1'b0;
            pte_use[p]   = 1'b0;
          end
          o.status = pmm_pkg::ST_OK;
        end
      end
      default: begin
        for (int i = 0; i < RS; i++)
          if (rgn_valid[i] && rgn_pid[i] == int'(r.pid) && va >= rgn_base[i] &&
              va < rgn_base[i] + rgn_size[i]) begin
            slot = i; break;
          end
        if (slot < 0) o.status = pmm_pkg::ST_NOREC;
        else begin
          v   = va / PB;
          off = va % PB;
          if (pte_res[v]) begin
            pte_use[v] = 1'b1;
            found      = 1'b1;
          end else begin
            // clock hand runs downward from v/4, wrapping at page 0
            s = v / 4;
            for (n = 0; n < 2 * VP; n++) begin
              if (pte_res[s]) begin
                if (pte_use[s]) pte_use[s] = 1'b0;
                else begin found = 1'b1; break; end
              end
              s = (s == 0) ? VP - 1 : s - 1;
            end
            if (found) begin
              pte_frame[v]   = pte_frame[s];
              pte_res[v]     = 1'b1;
              pte_use[v]     = 1'b1;
              pte_frame[s]   = 0;
              pte_res[s]     = 1'b0;
              pte_use[s]     = 1'b0;
              o.swapped      = 1'b1;
              o.evicted_page = 10'(s);
              o.fetched_page = 10'(v);
            end
          end
          if (found) begin
            o.status    = pmm_pkg::ST_OK;
            o.phys_addr = 20'(pte_frame[v] * PB + off);
          end else o.status = pmm_pkg::ST_NORES;
        end
      end
    endcase
    return o;
  endfunction

  // ---- directed table ----
  typedef struct {
    pmm_pkg::req_t r;
    bit            typed;
    pmm_pkg::rsp_t exp;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic dir_row_t row(logic [1:0] a, int pid, int va, int sz,
                                   bit typed, logic [2:0] st, int base);
    dir_row_t d;
    d.r.action   = a;
    d.r.pid      = 10'(pid);
    d.r.vaddr    = 22'(va);
    d.r.req_size = 23'(sz);
    d.typed      = typed;
    d.exp        = '0;
    d.exp.status = st;
    d.exp.alloc_base = 22'(base);
    return d;
  endfunction

  // Random word: mostly well-formed traffic on live regions, some noise.
  function automatic pmm_pkg::req_t random_req();
    pmm_pkg::req_t r;
    int   live[$];
    int   k, dice;
    r    = '0;
    dice = $urandom_range(0, 99);
    for (int i = 0; i < RS; i++) if (rgn_valid[i]) live.push_back(i);
    if (live.size() == 0 && dice < 60) dice = 60;
    k = (live.size() > 0) ? live[$urandom_range(0, live.size() - 1)] : 0;
    if (dice < 42) begin
      r.action = $urandom_range(0, 1) ? pmm_pkg::ACT_WRITE : pmm_pkg::ACT_READ;
      r.pid    = 10'(rgn_pid[k]);
      r.vaddr  = 22'(rgn_base[k] + $urandom_range(0, rgn_size[k] - 1));
    end else if (dice < 58) begin
      r.action = pmm_pkg::ACT_FREE;
      r.pid    = 10'(rgn_pid[k]);
      r.vaddr  = 22'(rgn_base[k]);
    end else if (dice < 84) begin
      r.action = pmm_pkg::ACT_ALLOC;
      r.pid    = 10'($urandom);
      dice     = $urandom_range(0, 9);
      r.req_size = 23'((dice < 7) ? $urandom_range(1, 8 * PB) :
                       (dice < 9) ? $urandom_range(1, 64 * PB) :
                                    $urandom_range(1, 400 * PB));
    end else r = pmm_pkg::req_t'(REQ_W'({$urandom, $urandom}));
    return r;
  endfunction

  // ---- result checking: done words cannot be stalled ----
  always @(posedge clk) begin
    pmm_pkg::rsp_t e;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", rsp);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status || rsp.phys_addr !== e.phys_addr ||
            rsp.alloc_base !== e.alloc_base || rsp.swapped !== e.swapped ||
            rsp.evicted_page !== e.evicted_page ||
            rsp.fetched_page !== e.fetched_page) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp st=%0d pa=%h base=%h sw=%b ev=%0d fe=%0d",
                      " | got st=%0d pa=%h base=%h sw=%b ev=%0d fe=%0d"},
                     e.status, e.phys_addr, e.alloc_base, e.swapped, e.evicted_page,
                     e.fetched_page, rsp.status, rsp.phys_addr, rsp.alloc_base,
                     rsp.swapped, rsp.evicted_page, rsp.fetched_page);
        end
      end
    end
  end

  // ---- watchdog: cycles with neither a request nor a result accepted ----
  always @(posedge clk) begin
    if ((start && !busy && !rst) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---- stimulus ----
  initial begin
    pmm_pkg::req_t nxt;
    pmm_pkg::rsp_t pr;
    int   total, gap, phase;
    mismatches  = 0;
    idle_cycles = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;

    // after reset, extremes and error codes
    dir_tab.push_back(row(pmm_pkg::ACT_READ,  0,    0,        0, 1, pmm_pkg::ST_NOREC, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_WRITE, 1023, VBYTES-1, 0, 1, pmm_pkg::ST_NOREC, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_FREE,  7,    0,        0, 1, pmm_pkg::ST_NOREC, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_ALLOC, 3,    0,        0, 1, pmm_pkg::ST_SPACE, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_ALLOC, 3,    0,  8388607, 1, pmm_pkg::ST_SPACE, 0));
    // frames run out: page 256 allocated but not resident
    dir_tab.push_back(row(pmm_pkg::ACT_ALLOC, 10, 0, 257 * PB, 1, pmm_pkg::ST_OK, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_ALLOC, 11, 0, 1, 1, pmm_pkg::ST_OK, 257 * PB));
    dir_tab.push_back(row(pmm_pkg::ACT_FREE,  10, 0, 0, 1, pmm_pkg::ST_OK, 0));
    // no resident page anywhere; one-byte region rejects other offsets
    dir_tab.push_back(row(pmm_pkg::ACT_READ,  11, 257 * PB,       0, 1, pmm_pkg::ST_NORES, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_WRITE, 11, 257 * PB + 100, 0, 1, pmm_pkg::ST_NOREC, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_FREE,  11, 257 * PB + 1,   0, 1, pmm_pkg::ST_NOREC, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_FREE,  11, 257 * PB,       0, 1, pmm_pkg::ST_OK, 0));
    // whole space in one region, then misses from the top
    dir_tab.push_back(row(pmm_pkg::ACT_ALLOC, 999, 0, VBYTES, 1, pmm_pkg::ST_OK, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_READ,  999, VBYTES-1, 0, 0, pmm_pkg::ST_OK, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_WRITE, 999, 0,        0, 0, pmm_pkg::ST_OK, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_ALLOC, 1,   0,        1, 1, pmm_pkg::ST_SPACE, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_READ,  998, PB,       0, 1, pmm_pkg::ST_NOREC, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_READ,  999, 300 * PB, 0, 0, pmm_pkg::ST_OK, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_FREE,  999, 0,        0, 1, pmm_pkg::ST_OK, 0));
    // pid 1000 is ordinary; size not a page multiple
    dir_tab.push_back(row(pmm_pkg::ACT_ALLOC, 1000, 0, PB + 1,  1, pmm_pkg::ST_OK, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_WRITE, 1000, PB,     0,  0, pmm_pkg::ST_OK, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_READ,  1000, PB + 1, 0,  1, pmm_pkg::ST_NOREC, 0));
    dir_tab.push_back(row(pmm_pkg::ACT_FREE,  1000, 0,      0,  1, pmm_pkg::ST_OK, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    total = dir_tab.size() + RANDOM_WORDS;
    for (int i = 0; i < total; i++) begin
      nxt = (i < dir_tab.size()) ? dir_tab[i].r : random_req();
      // sender gap per phase: none, heavy, none (receiver cannot stall), light
      phase = (i * 4) / total;
      gap   = 0;
      if (phase == 1) while ($urandom_range(0, 99) < 83) gap++;
      if (phase == 3) while ($urandom_range(0, 99) < 30) gap++;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      start <= 1'b1;
      req   <= nxt;
      do @(posedge clk); while (busy);
      pr = predict_rsp(nxt);
      if (i < dir_tab.size() && dir_tab[i].typed) pr = dir_tab[i].exp;
      pending_rsp.push_back(pr);
    end
    start <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pmm_pkg.sv
hw/rtl/pmm_dpath.sv
hw/rtl/pmm_ctrl.sv
hw/rtl/paged_memory_manager_clock.sv
dv/tb_paged_memory_manager_clock.sv
